// ===== rtl/core/ptt_pkg.sv =====
// Shared types and constants for the packet timestamp trimmer.
// No dependencies; imported by every module of the block.
package ptt_pkg;

	localparam int STAMP_W  = 64;
	localparam int SEC_W    = 24;
	localparam int NUM_W    = 16;
	localparam int DEN_W    = 32;
	localparam int SN_W     = 4;
	localparam int KIND_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int MAG_W    = STAMP_W - 1;
	localparam int MAG_LO_W = 32;
	localparam int MAG_HI_W = MAG_W - MAG_LO_W;
	localparam int PROD_W   = MAG_W + NUM_W;
	localparam int PROD_HI_W = MAG_HI_W + NUM_W;
	localparam int PROD_LO_W = MAG_LO_W + NUM_W;
	localparam int LIM_W    = SEC_W + DEN_W;

	localparam logic [KIND_W-1:0] KIND_AUDIO = 2'd1;
	localparam logic [KIND_W-1:0] KIND_VIDEO = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_START_SECONDS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_SECONDS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_STREAM  = 2'd2;

	typedef enum logic [1:0] {
		VERDICT_FWD      = 2'd0,
		VERDICT_DROP     = 2'd1,
		VERDICT_WAIT_KEY = 2'd2,
		VERDICT_FINISHED = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [SN_W-1:0]    stream_number;
		logic [KIND_W-1:0]  stream_kind;
		logic [STAMP_W-1:0] pres_stamp;
		logic               pres_present;
		logic [STAMP_W-1:0] dec_stamp;
		logic               dec_present;
		logic               is_keyframe;
		logic [NUM_W-1:0]   base_num;
		logic [DEN_W-1:0]   base_den;
	} pkt_t;

	typedef struct packed {
		logic before_start;
		logic past_end;
	} win_t;

endpackage

// ===== rtl/core/ptt_window.sv =====
// Trim window check: input register, cross-multiply stage, compare stage.
// Depends on ptt_pkg.
module ptt_window
	import ptt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [SEC_W-1:0] start_seconds,
	input  logic [SEC_W-1:0] end_seconds,
	input  logic             in_valid,
	output logic             in_stall,
	input  pkt_t             in_pkt,
	output logic             dn_valid,
	input  logic             dn_ready,
	output pkt_t             dn_pkt,
	output win_t             dn_win
);

	logic                 v_s1, v_s2, v_s3;
	logic                 rdy_s1, rdy_s2, rdy_s3;
	pkt_t                 pkt_s1, pkt_s2, pkt_s3;
	logic [PROD_HI_W-1:0] prod_hi_s2;
	logic [PROD_LO_W-1:0] prod_lo_s2;
	logic [LIM_W-1:0]     lim_start_s2, lim_end_s2;
	logic                 force_before_s2;
	win_t                 win_s3;

	logic [STAMP_W-1:0] stamp;
	logic [MAG_W-1:0]   mag;
	logic [DEN_W-1:0]   den;
	logic               force_before;
	logic [PROD_W-1:0]  prod;
	win_t               win_c;

	assign rdy_s3   = !v_s3 || dn_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_comb begin
		stamp = pkt_s1.pres_present ? pkt_s1.pres_stamp : pkt_s1.dec_stamp;
		mag   = stamp[STAMP_W-1] ? '0 : stamp[MAG_W-1:0];
		den   = (pkt_s1.base_den == '0) ? DEN_W'(1) : pkt_s1.base_den;
		force_before = (!pkt_s1.pres_present && !pkt_s1.dec_present)
			|| (stamp[STAMP_W-1] && pkt_s1.base_num != '0);
	end

	always_comb begin
		prod = (PROD_W'(prod_hi_s2) << MAG_LO_W) + PROD_W'(prod_lo_s2);
		win_c.past_end     = !force_before_s2 && !(prod < PROD_W'(lim_end_s2));
		win_c.before_start = force_before_s2 || (prod < PROD_W'(lim_start_s2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) pkt_s1 <= in_pkt;
		if (rdy_s2 && v_s1) begin
			pkt_s2          <= pkt_s1;
			prod_hi_s2      <= PROD_HI_W'(mag[MAG_W-1:MAG_LO_W])
				* PROD_HI_W'(pkt_s1.base_num);
			prod_lo_s2      <= PROD_LO_W'(mag[MAG_LO_W-1:0]) * PROD_LO_W'(pkt_s1.base_num);
			lim_start_s2    <= LIM_W'(start_seconds) * LIM_W'(den);
			lim_end_s2      <= LIM_W'(end_seconds) * LIM_W'(den);
			force_before_s2 <= force_before;
		end
		if (rdy_s3 && v_s2) begin
			pkt_s3 <= pkt_s2;
			win_s3 <= win_c;
		end
	end

	assign dn_valid = v_s3;
	assign dn_pkt   = pkt_s3;
	assign dn_win   = win_s3;

endmodule

// ===== rtl/core/ptt_state.sv =====
// Per-stream state, verdict, rebasing and result register.
// Depends on ptt_pkg.
module ptt_state
	import ptt_pkg::*;
#(
	parameter int MAX_STREAMS = 16
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [SN_W-1:0]    video_stream,
	input  logic               up_valid,
	output logic               up_ready,
	input  pkt_t               up_pkt,
	input  win_t               up_win,
	output logic               out_valid,
	input  logic               out_stall,
	output verdict_t           verdict,
	output logic [SN_W-1:0]    pkt_stream,
	output logic [STAMP_W-1:0] out_pres,
	output logic               out_pres_present,
	output logic [STAMP_W-1:0] out_dec,
	output logic               out_dec_present
);

	localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

	logic               finished_q, keyframe_seen_q, prior_valid_q;
	logic [STAMP_W-1:0] prior_dec_q;
	logic [STAMP_W-1:0] base_pres_q [MAX_STREAMS];
	logic [STAMP_W-1:0] base_dec_q  [MAX_STREAMS];
	logic [MAX_STREAMS-1:0] base_captured_q;

	logic               out_valid_q;
	verdict_t           verdict_q;
	logic [SN_W-1:0]    pkt_stream_q;
	logic [STAMP_W-1:0] out_pres_q, out_dec_q;
	logic               out_pres_present_q, out_dec_present_q;

	logic               take, media, is_video, fwd, cap, base_wr, prior_wr, set_fin, set_key;
	logic [IDX_W-1:0]   idx;
	logic [STAMP_W-1:0] bp, bd, pres_r, dec_r, dec_m, pres_f, prior_inc;
	verdict_t           verdict_c;

	assign up_ready = !out_valid_q || !out_stall;
	assign take     = up_valid && up_ready;

	always_comb begin
		idx      = IDX_W'(up_pkt.stream_number);
		media    = (up_pkt.stream_kind == KIND_AUDIO || up_pkt.stream_kind == KIND_VIDEO)
			&& (int'(up_pkt.stream_number) < MAX_STREAMS);
		is_video = (up_pkt.stream_number == video_stream);
		set_fin  = 1'b0;
		set_key  = 1'b0;
		fwd      = 1'b0;
		if (finished_q) begin
			verdict_c = VERDICT_FINISHED;
		end else if (!media) begin
			verdict_c = VERDICT_DROP;
		end else if (up_win.past_end) begin
			verdict_c = VERDICT_FINISHED;
			set_fin   = 1'b1;
		end else if (up_win.before_start) begin
			verdict_c = VERDICT_DROP;
		end else if (is_video && !keyframe_seen_q && !up_pkt.is_keyframe) begin
			verdict_c = VERDICT_WAIT_KEY;
		end else begin
			verdict_c = VERDICT_FWD;
			fwd       = 1'b1;
			set_key   = is_video;
		end

		cap     = base_captured_q[idx];
		base_wr = fwd && !cap;
		bp = cap ? base_pres_q[idx] : (up_pkt.pres_present ? up_pkt.pres_stamp : '0);
		bd = cap ? base_dec_q[idx]  : (up_pkt.dec_present  ? up_pkt.dec_stamp  : '0);
		pres_r    = up_pkt.pres_stamp - bp;
		dec_r     = up_pkt.dec_stamp - bd;
		prior_inc = prior_dec_q + STAMP_W'(1);
		prior_wr  = fwd && up_pkt.dec_present && is_video;
		if (is_video && prior_valid_q && ($signed(prior_dec_q) >= $signed(dec_r)))
			dec_m = prior_inc;
		else
			dec_m = dec_r;
		if (is_video && up_pkt.pres_present && up_pkt.dec_present
			&& ($signed(pres_r) < $signed(dec_m)))
			pres_f = dec_m;
		else
			pres_f = pres_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finished_q      <= 1'b0;
			keyframe_seen_q <= 1'b0;
			prior_valid_q   <= 1'b0;
			base_captured_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (up_ready) out_valid_q <= up_valid;
			if (take) begin
				if (set_fin) finished_q <= 1'b1;
				if (set_key) keyframe_seen_q <= 1'b1;
				if (prior_wr) prior_valid_q <= 1'b1;
				if (base_wr) base_captured_q[idx] <= up_pkt.pres_present;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && base_wr) begin
			base_pres_q[idx] <= bp;
			base_dec_q[idx]  <= bd;
		end
		if (take && prior_wr) prior_dec_q <= dec_m;
		if (take) begin
			verdict_q          <= verdict_c;
			pkt_stream_q       <= up_pkt.stream_number;
			out_pres_q         <= (fwd && up_pkt.pres_present) ? pres_f : '0;
			out_pres_present_q <= fwd && up_pkt.pres_present;
			out_dec_q          <= (fwd && up_pkt.dec_present) ? dec_m : '0;
			out_dec_present_q  <= fwd && up_pkt.dec_present;
		end
	end

	assign out_valid        = out_valid_q;
	assign verdict          = verdict_q;
	assign pkt_stream       = pkt_stream_q;
	assign out_pres         = out_pres_q;
	assign out_pres_present = out_pres_present_q;
	assign out_dec          = out_dec_q;
	assign out_dec_present  = out_dec_present_q;

`ifndef SYNTH
	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("finished flag cleared");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q != VERDICT_FWD) |->
		(out_pres_q == '0 && out_dec_q == '0 && !out_pres_present_q && !out_dec_present_q))
		else $error("dropped beat carries stamps");

	a_take_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q)
		else $error("accepted beat not presented");

	a_video_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q == VERDICT_FWD && pkt_stream_q == video_stream
		&& out_pres_present_q && out_dec_present_q) |->
		($signed(out_pres_q) >= $signed(out_dec_q)))
		else $error("video presentation stamp below decode stamp");
`endif

endmodule

// ===== rtl/core/packet_timestamp_trimmer_unit.sv =====
// Packet timestamp trimmer top level: configuration registers and stage wiring.
// An accepted input beat passes the window input, multiply and compare registers, then the state result register.
// Throughput: one beat per cycle while out_stall is low; the window check multiplies and
// the per-stream state update are each one pipeline stage, so no stage holds an item longer unless stalled.
// Reset: arst_n clears the configuration, finished, keyframe and captured flags;
// stored base stamps stay undefined until written, with no clearing pass.
module packet_timestamp_trimmer_unit
	import ptt_pkg::*;
#(
	parameter int MAX_STREAMS = 16
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SEC_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SN_W-1:0]      stream_number,
	input  logic [KIND_W-1:0]    stream_kind,
	input  logic [STAMP_W-1:0]   pres_stamp,
	input  logic                 pres_present,
	input  logic [STAMP_W-1:0]   dec_stamp,
	input  logic                 dec_present,
	input  logic                 is_keyframe,
	input  logic [NUM_W-1:0]     base_num,
	input  logic [DEN_W-1:0]     base_den,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           verdict,
	output logic [SN_W-1:0]      pkt_stream,
	output logic [STAMP_W-1:0]   out_pres,
	output logic                 out_pres_present,
	output logic [STAMP_W-1:0]   out_dec,
	output logic                 out_dec_present
);

	logic [SEC_W-1:0] start_seconds_q, end_seconds_q;
	logic [SN_W-1:0]  video_stream_q;
	pkt_t             in_pkt, mid_pkt;
	win_t             mid_win;
	logic             mid_valid, mid_ready;
	verdict_t         verdict_w;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_seconds_q <= '0;
			end_seconds_q   <= '0;
			video_stream_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_SECONDS: start_seconds_q <= cfg_data;
				CFG_END_SECONDS:   end_seconds_q   <= cfg_data;
				CFG_VIDEO_STREAM:  video_stream_q  <= cfg_data[SN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		in_pkt.stream_number = stream_number;
		in_pkt.stream_kind   = stream_kind;
		in_pkt.pres_stamp    = pres_stamp;
		in_pkt.pres_present  = pres_present;
		in_pkt.dec_stamp     = dec_stamp;
		in_pkt.dec_present   = dec_present;
		in_pkt.is_keyframe   = is_keyframe;
		in_pkt.base_num      = base_num;
		in_pkt.base_den      = base_den;
	end

	ptt_window u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.start_seconds (start_seconds_q),
		.end_seconds   (end_seconds_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_pkt        (in_pkt),
		.dn_valid      (mid_valid),
		.dn_ready      (mid_ready),
		.dn_pkt        (mid_pkt),
		.dn_win        (mid_win)
	);

	ptt_state #(
		.MAX_STREAMS (MAX_STREAMS)
	) u_state (
		.clk              (clk),
		.arst_n           (arst_n),
		.video_stream     (video_stream_q),
		.up_valid         (mid_valid),
		.up_ready         (mid_ready),
		.up_pkt           (mid_pkt),
		.up_win           (mid_win),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.verdict          (verdict_w),
		.pkt_stream       (pkt_stream),
		.out_pres         (out_pres),
		.out_pres_present (out_pres_present),
		.out_dec          (out_dec),
		.out_dec_present  (out_dec_present)
	);

	assign verdict = verdict_w;

endmodule
